// ===== src/roimc_pkg.sv =====
// Shared widths, register indexes, queue entry types and helpers for the ROI mean color block.
package roimc_pkg;

  localparam int COORD_W    = 11;
  localparam int CHAN_W     = 8;
  localparam int SIZE_W     = 9;
  localparam int FRAMES_W   = 8;
  localparam int SUM_W      = 24;
  localparam int TOTAL_W    = 16;
  localparam int DIVISOR_W  = 2 * SIZE_W;
  localparam int NUM_CH     = 3;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int STEP_W     = $clog2(SUM_W);
  localparam int JOB_DEPTH  = 2;
  localparam int RES_DEPTH  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_COL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_ROW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_SIZE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES   = 2'd3;

  localparam logic [SIZE_W-1:0]   BOX_SIZE_RESET = 9'd16;
  localparam logic [FRAMES_W-1:0] FRAMES_RESET   = 8'd1;

  typedef logic [NUM_CH-1:0][SUM_W-1:0] sums_t;

  typedef struct packed {
    sums_t                sums;
    logic [SIZE_W-1:0]    size;
    logic [FRAMES_W-1:0]  frames;
  } job_t;

  typedef struct packed {
    logic [NUM_CH-1:0][CHAN_W-1:0] frame_mean;
    logic [NUM_CH-1:0][CHAN_W-1:0] average;
    logic                          average_ready;
  } result_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MEAN,
    B_AVG,
    B_PUSH
  } back_state_t;

  function automatic logic [CHAN_W-1:0] sat_chan(input logic [SUM_W-1:0] value);
    logic [CHAN_W-1:0] result;
    if (|value[SUM_W-1:CHAN_W]) begin
      result = '1;
    end else begin
      result = value[CHAN_W-1:0];
    end
    return result;
  endfunction

endpackage

// ===== src/roimc_fifo.sv =====
// Small register queue used between the front and back parts and on the result side.
module roimc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/roimc_front.sv =====
// Front part: configuration registers, box test and per-channel sums over each frame.
module roimc_front
  import roimc_pkg::*;
#(
  parameter int MAX_BOX    = 256,
  parameter int MAX_COORD  = 2048,
  parameter int MAX_FRAMES = 255
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 accept,
  input  logic [COORD_W-1:0]   pixel_col,
  input  logic [COORD_W-1:0]   pixel_row,
  input  logic [CHAN_W-1:0]    blue,
  input  logic [CHAN_W-1:0]    green,
  input  logic [CHAN_W-1:0]    red,
  input  logic                 last_in_frame,
  output logic                 job_push,
  output job_t                 job
);

  localparam int WIDE_W = 17;

  logic [COORD_W-1:0]  box_col;
  logic [COORD_W-1:0]  box_row;
  logic [SIZE_W-1:0]   box_size;
  logic [FRAMES_W-1:0] frames_to_average;
  sums_t               sums;
  sums_t               sums_next;
  logic [SIZE_W-1:0]   size_eff;
  logic [FRAMES_W-1:0] frames_eff;
  logic [COORD_W:0]    col_end;
  logic [COORD_W:0]    row_end;
  logic                in_frame;
  logic                in_box;
  logic [NUM_CH-1:0][CHAN_W-1:0] chan;
  logic [SUM_W:0]      sum_add [NUM_CH];

  always_ff @(posedge clk) begin
    if (rst) begin
      box_col           <= '0;
      box_row           <= '0;
      box_size          <= BOX_SIZE_RESET;
      frames_to_average <= FRAMES_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BOX_COL:  box_col           <= cfg_data[COORD_W-1:0];
        REG_BOX_ROW:  box_row           <= cfg_data[COORD_W-1:0];
        REG_BOX_SIZE: box_size          <= cfg_data[SIZE_W-1:0];
        REG_FRAMES:   frames_to_average <= cfg_data[FRAMES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (WIDE_W'(box_size) > WIDE_W'(MAX_BOX)) begin
      size_eff = SIZE_W'(MAX_BOX);
    end else begin
      size_eff = box_size;
    end
    if (frames_to_average == '0) begin
      frames_eff = FRAMES_W'(1);
    end else if (WIDE_W'(frames_to_average) > WIDE_W'(MAX_FRAMES)) begin
      frames_eff = FRAMES_W'(MAX_FRAMES);
    end else begin
      frames_eff = frames_to_average;
    end
  end

  assign col_end  = {1'b0, box_col} + (COORD_W + 1)'(size_eff);
  assign row_end  = {1'b0, box_row} + (COORD_W + 1)'(size_eff);
  assign in_frame = (WIDE_W'(pixel_col) < WIDE_W'(MAX_COORD)) &&
                    (WIDE_W'(pixel_row) < WIDE_W'(MAX_COORD));
  assign in_box   = in_frame &&
                    (pixel_col >= box_col) && ({1'b0, pixel_col} < col_end) &&
                    (pixel_row >= box_row) && ({1'b0, pixel_row} < row_end);
  assign chan     = {red, green, blue};

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      sum_add[k] = {1'b0, sums[k]} + (SUM_W + 1)'(chan[k]);
      if (!in_box) begin
        sums_next[k] = sums[k];
      end else if (sum_add[k][SUM_W]) begin
        sums_next[k] = '1;
      end else begin
        sums_next[k] = sum_add[k][SUM_W-1:0];
      end
    end
  end

  assign job_push   = accept && last_in_frame;
  assign job.sums   = sums_next;
  assign job.size   = size_eff;
  assign job.frames = frames_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      sums <= '0;
    end else if (accept) begin
      if (last_in_frame) begin
        sums <= '0;
      end else begin
        sums <= sums_next;
      end
    end
  end

endmodule

// ===== src/roimc_div.sv =====
// Three-lane restoring divider with a shared divisor, one quotient bit per cycle.
module roimc_div
  import roimc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIVISOR_W-1:0] divisor,
  input  sums_t                dividend,
  output logic                 busy,
  output logic                 done,
  output sums_t                quotient
);

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

  logic [STEP_W-1:0]    step;
  logic [DIVISOR_W-1:0] dvs;
  logic [DIVISOR_W-1:0] rem      [NUM_CH];
  logic [DIVISOR_W-1:0] rem_next [NUM_CH];
  logic [DIVISOR_W:0]   rem_sh   [NUM_CH];
  logic [DIVISOR_W:0]   rem_diff [NUM_CH];
  logic [NUM_CH-1:0]    fits;
  sums_t                quo;

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      rem_sh[k]   = {rem[k], quo[k][SUM_W-1]};
      rem_diff[k] = rem_sh[k] - {1'b0, dvs};
      fits[k]     = (rem_sh[k] >= {1'b0, dvs});
      rem_next[k] = fits[k] ? rem_diff[k][DIVISOR_W-1:0] : rem_sh[k][DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      dvs <= divisor;
      for (int k = 0; k < NUM_CH; k++) begin
        rem[k] <= '0;
      end
    end else if (busy) begin
      for (int k = 0; k < NUM_CH; k++) begin
        rem[k] <= rem_next[k];
        quo[k] <= {quo[k][SUM_W-2:0], fits[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = (dvs == '0) ? '0 : quo;

endmodule

// ===== src/roimc_back.sv =====
// Back part: per-frame means, running totals and the average over several frames.
module roimc_back
  import roimc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    job_empty,
  input  job_t    job_head,
  output logic    job_pop,
  input  logic    out_full,
  output logic    out_push,
  output result_t out_entry
);

  back_state_t          state;
  back_state_t          state_next;
  logic                 div_start;
  logic                 div_busy;
  logic                 div_done;
  logic [DIVISOR_W-1:0] div_divisor;
  sums_t                div_dividend;
  sums_t                div_quotient;
  logic [DIVISOR_W-1:0] size_sq;
  logic [NUM_CH-1:0][TOTAL_W-1:0] totals;
  logic [NUM_CH-1:0][TOTAL_W-1:0] totals_upd;
  logic [NUM_CH-1:0][CHAN_W-1:0]  mean_sat;
  logic [NUM_CH-1:0][CHAN_W-1:0]  means;
  logic [NUM_CH-1:0][CHAN_W-1:0]  avg;
  logic [TOTAL_W:0]     total_sum [NUM_CH];
  logic [FRAMES_W-1:0]  count;
  logic [FRAMES_W:0]    count_upd;
  logic [FRAMES_W-1:0]  frames_n;
  logic                 ready;
  logic                 reach;

  roimc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (div_divisor),
    .dividend (div_dividend),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign size_sq = DIVISOR_W'(job_head.size) * DIVISOR_W'(job_head.size);

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      mean_sat[k]  = sat_chan(div_quotient[k]);
      total_sum[k] = {1'b0, totals[k]} + (TOTAL_W + 1)'(mean_sat[k]);
      totals_upd[k] = total_sum[k][TOTAL_W] ? '1 : total_sum[k][TOTAL_W-1:0];
    end
    count_upd = {1'b0, count} + 1'b1;
    reach     = (count_upd >= {1'b0, frames_n});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    job_pop      = 1'b0;
    div_start    = 1'b0;
    div_divisor  = '0;
    div_dividend = '0;
    out_push     = 1'b0;
    case (state)
      B_IDLE: begin
        if (!job_empty) begin
          job_pop      = 1'b1;
          div_start    = 1'b1;
          div_divisor  = size_sq;
          div_dividend = job_head.sums;
          state_next   = B_MEAN;
        end
      end
      B_MEAN: begin
        if (div_done) begin
          if (reach) begin
            div_start   = 1'b1;
            div_divisor = DIVISOR_W'(frames_n);
            for (int k = 0; k < NUM_CH; k++) begin
              div_dividend[k] = SUM_W'(totals_upd[k]);
            end
            state_next = B_AVG;
          end else begin
            state_next = B_PUSH;
          end
        end
      end
      B_AVG: begin
        if (div_done) begin
          state_next = B_PUSH;
        end
      end
      B_PUSH: begin
        if (!out_full) begin
          out_push   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && job_pop) begin
      frames_n <= job_head.frames;
    end
    if (state == B_MEAN && div_done) begin
      means <= mean_sat;
      avg   <= '0;
    end
    if (state == B_AVG && div_done) begin
      for (int k = 0; k < NUM_CH; k++) begin
        avg[k] <= sat_chan(div_quotient[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      totals <= '0;
      count  <= '0;
      ready  <= 1'b0;
    end else if (state == B_MEAN && div_done) begin
      if (reach) begin
        totals <= '0;
        count  <= '0;
        ready  <= 1'b1;
      end else begin
        totals <= totals_upd;
        count  <= count_upd[FRAMES_W-1:0];
        ready  <= 1'b0;
      end
    end
  end

  assign out_entry.frame_mean    = means;
  assign out_entry.average       = avg;
  assign out_entry.average_ready = ready;

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_push_space: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !out_full)
    else $error("result pushed into a full queue");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> !job_empty)
    else $error("job popped from an empty queue");

  a_ready_count: assert property (@(posedge clk) disable iff (rst)
    (state == B_PUSH && ready) |-> (count == '0 && totals == '0))
    else $error("average given without restarting the totals");

  a_done_waiting: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == B_MEAN || state == B_AVG))
    else $error("divider finished with no one waiting");

endmodule

// ===== src/roi_mean_color_over_frames.sv =====
// Top level of the ROI mean color block: front, job queue, back and result queue.
// Pixels are taken one per cycle while full is low; full rises only when two frame ends wait in the job queue.
// A frame end reaches the result side after one division of its sums, and after a second one when an
// average completes; the 24-step shared divider in the back part carries out both.
// Reset (synchronous, active high) restores the register defaults, clears the sums,
// totals and frame count, and empties both queues.
module roi_mean_color_over_frames
  import roimc_pkg::*;
#(
  parameter int MAX_BOX    = 256,
  parameter int MAX_COORD  = 2048,
  parameter int MAX_FRAMES = 255
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 push,
  output logic                 full,
  input  logic [COORD_W-1:0]   pixel_col,
  input  logic [COORD_W-1:0]   pixel_row,
  input  logic [CHAN_W-1:0]    blue,
  input  logic [CHAN_W-1:0]    green,
  input  logic [CHAN_W-1:0]    red,
  input  logic                 last_in_frame,
  output logic                 empty,
  input  logic                 pop,
  output logic [CHAN_W-1:0]    frame_blue,
  output logic [CHAN_W-1:0]    frame_green,
  output logic [CHAN_W-1:0]    frame_red,
  output logic [CHAN_W-1:0]    average_blue,
  output logic [CHAN_W-1:0]    average_green,
  output logic [CHAN_W-1:0]    average_red,
  output logic                 average_ready
);

  logic    accept;
  logic    job_push;
  job_t    job_in;
  job_t    job_head;
  logic    job_full;
  logic    job_empty;
  logic    job_pop;
  logic    out_push;
  logic    out_full;
  result_t out_entry;
  result_t res_head;

  assign accept = push && !full;
  assign full   = job_full;

  roimc_front #(
    .MAX_BOX    (MAX_BOX),
    .MAX_COORD  (MAX_COORD),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .accept        (accept),
    .pixel_col     (pixel_col),
    .pixel_row     (pixel_row),
    .blue          (blue),
    .green         (green),
    .red           (red),
    .last_in_frame (last_in_frame),
    .job_push      (job_push),
    .job           (job_in)
  );

  roimc_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .din   (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .dout  (job_head),
    .empty (job_empty)
  );

  roimc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (job_empty),
    .job_head  (job_head),
    .job_pop   (job_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_entry (out_entry)
  );

  roimc_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .din   (out_entry),
    .full  (out_full),
    .pop   (pop),
    .dout  (res_head),
    .empty (empty)
  );

  assign frame_blue    = res_head.frame_mean[0];
  assign frame_green   = res_head.frame_mean[1];
  assign frame_red     = res_head.frame_mean[2];
  assign average_blue  = res_head.average[0];
  assign average_green = res_head.average[1];
  assign average_red   = res_head.average[2];
  assign average_ready = res_head.average_ready;

endmodule

// ===== tb/tb_roi_mean_color_over_frames.sv =====
// Self-checking testbench for the ROI mean color block: directed table, random frames, predictor.
module tb_roi_mean_color_over_frames;
  timeunit 1ns;
  timeprecision 1ps;
  import roimc_pkg::*;

  localparam int unsigned BOX_LIMIT     = 256;
  localparam int unsigned FRAME_LIMIT   = 255;
  localparam int unsigned COORD_SPAN    = 1 << COORD_W;
  localparam int unsigned CHAN_MAX      = (1 << CHAN_W) - 1;
  localparam int unsigned SUM_CEIL      = (1 << SUM_W) - 1;
  localparam int unsigned TOTAL_CEIL    = (1 << TOTAL_W) - 1;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned DRAIN_TAIL    = 100;
  localparam int unsigned SAT_BURST     = 24;
  localparam int unsigned BEATS_PER_SET = 60;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [CHAN_W-1:0]  b, g, r;
    logic               last;
  } pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] frame_b, frame_g, frame_r;
    logic [CHAN_W-1:0] avg_b, avg_g, avg_r;
    logic              ready;
  } frame_stats_t;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    pixel_t               pix;
    logic                 typed;
    frame_stats_t         want;
  } stim_row_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 push = 1'b0;
  logic                 full;
  logic [COORD_W-1:0]   pixel_col = '0;
  logic [COORD_W-1:0]   pixel_row = '0;
  logic [CHAN_W-1:0]    blue = '0;
  logic [CHAN_W-1:0]    green = '0;
  logic [CHAN_W-1:0]    red = '0;
  logic                 last_in_frame = 1'b0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [CHAN_W-1:0]    frame_blue, frame_green, frame_red;
  logic [CHAN_W-1:0]    average_blue, average_green, average_red;
  logic                 average_ready;

  int unsigned box_left = 0;
  int unsigned box_top = 0;
  int unsigned box_side = BOX_SIZE_RESET;
  int unsigned frames_per_average = FRAMES_RESET;
  int unsigned chan_sums [3] = '{0, 0, 0};
  int unsigned color_totals [3] = '{0, 0, 0};
  int unsigned frames_seen = 0;

  frame_stats_t pending_frame_stats [$];
  stim_row_t    directed_rows [$];
  int unsigned  mismatches = 0;
  int unsigned  stall_cycles = 0;
  int           send_idle_pct = 27;
  int           recv_idle_pct = 53;

  roi_mean_color_over_frames uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full),
    .pixel_col(pixel_col), .pixel_row(pixel_row),
    .blue(blue), .green(green), .red(red), .last_in_frame(last_in_frame),
    .empty(empty), .pop(pop),
    .frame_blue(frame_blue), .frame_green(frame_green), .frame_red(frame_red),
    .average_blue(average_blue), .average_green(average_green), .average_red(average_red),
    .average_ready(average_ready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit predict_pixel(input pixel_t p, output frame_stats_t res);
    int unsigned side, area, n, s, m, t, a;
    int unsigned chan [3];
    int unsigned mean_v [3];
    int unsigned avg_v [3];
    bit hit;
    chan[0] = p.b;
    chan[1] = p.g;
    chan[2] = p.r;
    res = '0;
    side = (box_side > BOX_LIMIT) ? BOX_LIMIT : box_side;
    hit = p.col >= box_left && p.col < box_left + side &&
          p.row >= box_top && p.row < box_top + side;
    if (hit) begin
      for (int k = 0; k < 3; k++) begin
        s = chan_sums[k] + chan[k];
        chan_sums[k] = (s > SUM_CEIL) ? SUM_CEIL : s;
      end
    end
    if (!p.last) return 1'b0;
    area = side * side;
    n = (frames_per_average == 0) ? 1 :
        (frames_per_average > FRAME_LIMIT) ? FRAME_LIMIT : frames_per_average;
    frames_seen++;
    for (int k = 0; k < 3; k++) begin
      m = (area == 0) ? 0 : chan_sums[k] / area;
      if (m > CHAN_MAX) m = CHAN_MAX;
      mean_v[k] = m;
      t = color_totals[k] + m;
      color_totals[k] = (t > TOTAL_CEIL) ? TOTAL_CEIL : t;
      chan_sums[k] = 0;
      avg_v[k] = 0;
    end
    res.ready = (frames_seen >= n);
    if (res.ready) begin
      for (int k = 0; k < 3; k++) begin
        a = color_totals[k] / n;
        avg_v[k] = (a > CHAN_MAX) ? CHAN_MAX : a;
        color_totals[k] = 0;
      end
      frames_seen = 0;
    end
    res.frame_b = CHAN_W'(mean_v[0]);
    res.frame_g = CHAN_W'(mean_v[1]);
    res.frame_r = CHAN_W'(mean_v[2]);
    res.avg_b = CHAN_W'(avg_v[0]);
    res.avg_g = CHAN_W'(avg_v[1]);
    res.avg_r = CHAN_W'(avg_v[2]);
    return 1'b1;
  endfunction

  function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = CFG_W'(val);
    directed_rows.push_back(row);
  endfunction

  function automatic void add_pixel(input int unsigned col, input int unsigned row_n,
                                    input int unsigned b, input int unsigned g,
                                    input int unsigned r, input bit last);
    stim_row_t row;
    row = '0;
    row.pix = '{col: COORD_W'(col), row: COORD_W'(row_n), b: CHAN_W'(b), g: CHAN_W'(g),
                r: CHAN_W'(r), last: last};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_checked(input int unsigned col, input int unsigned row_n,
                                      input int unsigned b, input int unsigned g,
                                      input int unsigned r,
                                      input int unsigned fb, input int unsigned fg,
                                      input int unsigned fr, input int unsigned ab,
                                      input int unsigned ag, input int unsigned ar,
                                      input bit ready);
    stim_row_t row;
    row = '0;
    row.pix = '{col: COORD_W'(col), row: COORD_W'(row_n), b: CHAN_W'(b), g: CHAN_W'(g),
                r: CHAN_W'(r), last: 1'b1};
    row.typed = 1'b1;
    row.want = '{frame_b: CHAN_W'(fb), frame_g: CHAN_W'(fg), frame_r: CHAN_W'(fr),
                 avg_b: CHAN_W'(ab), avg_g: CHAN_W'(ag), avg_r: CHAN_W'(ar), ready: ready};
    directed_rows.push_back(row);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_BOX_COL:  box_left = val % COORD_SPAN;
      REG_BOX_ROW:  box_top = val % COORD_SPAN;
      REG_BOX_SIZE: box_side = val % (1 << SIZE_W);
      REG_FRAMES:   frames_per_average = val % (1 << FRAMES_W);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (pending_frame_stats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_pixel(input pixel_t p, input bit typed, input frame_stats_t want);
    frame_stats_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    pixel_col <= p.col;
    pixel_row <= p.row;
    blue <= p.b;
    green <= p.g;
    red <= p.r;
    last_in_frame <= p.last;
    do @(posedge clk); while (full);
    if (predict_pixel(p, res)) pending_frame_stats.push_back(typed ? want : res);
  endtask

  always @(posedge clk) pop <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin : result_check
    frame_stats_t want;
    if (!rst) begin
      if (pop && !empty) begin
        if (pending_frame_stats.size() == 0) begin
          $error("result beat with no frame end pending");
          mismatches++;
        end else begin
          want = pending_frame_stats.pop_front();
          check_field("frame_blue", want.frame_b, frame_blue);
          check_field("frame_green", want.frame_g, frame_green);
          check_field("frame_red", want.frame_r, frame_red);
          check_field("average_blue", want.avg_b, average_blue);
          check_field("average_green", want.avg_g, average_green);
          check_field("average_red", want.avg_r, average_red);
          check_field("average_ready", want.ready, average_ready);
        end
      end
      if ((push && !full) || (pop && !empty) || cfg_write) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  initial begin
    pixel_t p;
    int unsigned sent, w, h, pick, val;
    int ocol, orow;

    add_checked(0, 0, 255, 255, 255, 0, 0, 0, 0, 0, 0, 1'b1);
    add_reg(REG_BOX_SIZE, 1);
    add_pixel(0, 0, 255, 255, 255, 1'b0);
    add_checked(0, 0, 1, 0, 0, 255, 255, 255, 255, 255, 255, 1'b1);
    add_checked(2047, 2047, 255, 255, 255, 0, 0, 0, 0, 0, 0, 1'b1);
    add_checked(0, 0, 'h5A, 'hA5, 'h0F, 'h5A, 'hA5, 'h0F, 'h5A, 'hA5, 'h0F, 1'b1);
    add_reg(REG_BOX_SIZE, 0);
    add_checked(0, 0, 255, 255, 255, 0, 0, 0, 0, 0, 0, 1'b1);
    add_reg(REG_FRAMES, 0);
    add_reg(REG_BOX_SIZE, 2);
    add_pixel(0, 0, 200, 100, 40, 1'b0);
    add_pixel(1, 1, 200, 100, 40, 1'b0);
    add_pixel(1, 0, 0, 0, 0, 1'b0);
    add_pixel(2, 0, 255, 255, 255, 1'b0);
    add_pixel(0, 1, 4, 4, 4, 1'b1);
    add_reg(REG_BOX_COL, 2047);
    add_reg(REG_BOX_ROW, 2047);
    add_reg(REG_BOX_SIZE, 511);
    add_reg(REG_FRAMES, 255);
    add_pixel(2047, 2047, 255, 255, 255, 1'b0);
    add_checked(2046, 2047, 9, 9, 9, 0, 0, 0, 0, 0, 0, 1'b0);
    add_reg(REG_BOX_SIZE, 1);
    add_checked(2047, 2047, 255, 128, 1, 255, 128, 1, 0, 0, 0, 1'b0);
    add_reg(REG_FRAMES, 3);
    add_pixel(2047, 2047, 30, 60, 90, 1'b1);
    add_pixel(1024, 1024, 'h55, 'hAA, 'h33, 1'b0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        wait_idle();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        send_pixel(directed_rows[i].pix, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // A run on one coordinate drives the frame means into saturation.
    wait_idle();
    write_reg(REG_BOX_COL, 0);
    write_reg(REG_BOX_ROW, 0);
    write_reg(REG_BOX_SIZE, 1);
    write_reg(REG_FRAMES, 1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < SAT_BURST; i++) begin
      p = '{col: '0, row: '0, b: '1, g: '1, r: '1, last: (i == SAT_BURST - 1)};
      send_pixel(p, 1'b0, '0);
    end

    for (int regime = 0; regime < 3; regime++) begin
      send_idle_pct = (regime == 0) ? 27 : (regime == 1) ? 53 : 0;
      recv_idle_pct = (regime == 0) ? 53 : (regime == 1) ? 27 : 0;
      for (int setting = 0; setting < 4; setting++) begin
        wait_idle();
        pick = $urandom_range(99);
        val = (pick < 20) ? $urandom_range(2047, 2040) :
              (pick < 40) ? $urandom_range(3, 0) : $urandom_range(2047, 0);
        write_reg(REG_BOX_COL, val);
        pick = $urandom_range(99);
        val = (pick < 20) ? $urandom_range(2047, 2040) :
              (pick < 40) ? $urandom_range(3, 0) : $urandom_range(2047, 0);
        write_reg(REG_BOX_ROW, val);
        pick = $urandom_range(99);
        val = (pick < 5) ? 0 : (pick < 10) ? 256 :
              (pick < 15) ? $urandom_range(511, 257) : $urandom_range(6, 1);
        write_reg(REG_BOX_SIZE, val);
        pick = $urandom_range(99);
        val = (pick < 10) ? 0 : (pick < 15) ? 255 : $urandom_range(4, 1);
        write_reg(REG_FRAMES, val);
        sent = 0;
        while (sent < BEATS_PER_SET) begin
          if ($urandom_range(99) < 12) begin
            p = '{col: COORD_W'($urandom_range(2047, 0)),
                  row: COORD_W'($urandom_range(2047, 0)),
                  b: CHAN_W'($urandom_range(255, 0)), g: CHAN_W'($urandom_range(255, 0)),
                  r: CHAN_W'($urandom_range(255, 0)), last: ($urandom_range(7) == 0)};
            send_pixel(p, 1'b0, '0);
            sent++;
          end else begin
            w = $urandom_range(8, 1);
            h = $urandom_range(5, 1);
            ocol = int'(box_left) - int'($urandom_range(2, 0));
            orow = int'(box_top) - int'($urandom_range(2, 0));
            if (ocol < 0) ocol = 0;
            if (orow < 0) orow = 0;
            if (ocol + w > COORD_SPAN) ocol = COORD_SPAN - w;
            if (orow + h > COORD_SPAN) orow = COORD_SPAN - h;
            for (int y = 0; y < h; y++) begin
              for (int x = 0; x < w; x++) begin
                p = '{col: COORD_W'(ocol + x), row: COORD_W'(orow + y),
                      b: CHAN_W'($urandom_range(255, 0)),
                      g: CHAN_W'($urandom_range(255, 0)),
                      r: CHAN_W'($urandom_range(255, 0)),
                      last: (x == w - 1 && y == h - 1)};
                send_pixel(p, 1'b0, '0);
              end
            end
            sent += w * h;
            if ($urandom_range(14) == 0) wait_idle();
          end
        end
      end
    end

    wait_idle();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/roimc_pkg.sv
src/roimc_fifo.sv
src/roimc_front.sv
src/roimc_div.sv
src/roimc_back.sv
src/roi_mean_color_over_frames.sv
tb/tb_roi_mean_color_over_frames.sv
